// ----- rtl/core/sbrf_pkg.sv -----
`default_nettype none

package sbrf_pkg;

  // Defaults for the top-level parameters
  localparam int SCREEN_WIDTH_DEF  = 240;
  localparam int SCREEN_HEIGHT_DEF = 240;
  localparam int STRIP_ROWS_DEF    = 16;

  // Fixed field widths
  localparam int COORD_W = 16;
  localparam int COLOR_W = 16;
  localparam int INDEX_W = 12;
  localparam int TOP_OUT_W = 8;
  localparam int ROWS_OUT_W = 5;

  // Signed width for clip arithmetic: holds x+w, y+h and strip bottom
  localparam int CLIP_W = 18;

  typedef enum logic [1:0] {
    OP_FILL_RECT   = 2'd0,
    OP_BEGIN_FRAME = 2'd1,
    OP_NEXT_STRIP  = 2'd2,
    OP_READ_PIXEL  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PREP,
    ST_FILL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic prep;
    logic fill_step;
    logic clear_step;
    logic read_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    fill_empty;
    logic    more;
    logic    fill_last;
    logic    clear_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/core/sbrf_ctrl.sv -----
`default_nettype none

module sbrf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire sbrf_pkg::status_t status,
  output sbrf_pkg::cmd_t         cmd
);

  sbrf_pkg::state_t state, state_next;
  logic             out_valid_next;
  logic             can_load;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sbrf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sbrf_pkg::ST_IDLE: begin
        if (in_valid) state_next = sbrf_pkg::ST_EXEC;
      end
      sbrf_pkg::ST_EXEC: begin
        state_next = sbrf_pkg::ST_PREP;
      end
      sbrf_pkg::ST_PREP: begin
        case (status.op)
          sbrf_pkg::OP_FILL_RECT: begin
            state_next = status.fill_empty ? sbrf_pkg::ST_DONE : sbrf_pkg::ST_FILL;
          end
          sbrf_pkg::OP_BEGIN_FRAME: begin
            state_next = sbrf_pkg::ST_CLEAR;
          end
          sbrf_pkg::OP_NEXT_STRIP: begin
            state_next = status.more ? sbrf_pkg::ST_CLEAR : sbrf_pkg::ST_DONE;
          end
          sbrf_pkg::OP_READ_PIXEL: begin
            state_next = sbrf_pkg::ST_READ;
          end
          default: begin
            state_next = sbrf_pkg::ST_DONE;
          end
        endcase
      end
      sbrf_pkg::ST_FILL: begin
        if (status.fill_last) state_next = sbrf_pkg::ST_DONE;
      end
      sbrf_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = sbrf_pkg::ST_DONE;
      end
      sbrf_pkg::ST_READ: begin
        state_next = sbrf_pkg::ST_DONE;
      end
      sbrf_pkg::ST_DONE: begin
        if (can_load) state_next = sbrf_pkg::ST_IDLE;
      end
      default: begin
        state_next = sbrf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      sbrf_pkg::ST_IDLE: begin
        // nothing is taken while reset is held
        in_ready  = !rst;
        cmd.latch = in_valid && !rst;
      end
      sbrf_pkg::ST_EXEC:  cmd.exec       = 1'b1;
      sbrf_pkg::ST_PREP:  cmd.prep       = 1'b1;
      sbrf_pkg::ST_FILL:  cmd.fill_step  = 1'b1;
      sbrf_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      sbrf_pkg::ST_READ:  cmd.read_en    = 1'b1;
      sbrf_pkg::ST_DONE: begin
        cmd.load_out = can_load;
        if (can_load) out_valid_next = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // A request accepted always starts execution on the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == sbrf_pkg::ST_EXEC)
    else $error("accepted request did not start execution");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while pending");

  // A fill keeps stepping until its last pixel
  a_fill_runs: assert property (@(posedge clk) disable iff (rst)
    state == sbrf_pkg::ST_FILL && !status.fill_last |=> state == sbrf_pkg::ST_FILL)
    else $error("fill ended early");

  // An empty rectangle writes nothing
  a_empty_skip: assert property (@(posedge clk) disable iff (rst)
    state == sbrf_pkg::ST_PREP && status.op == sbrf_pkg::OP_FILL_RECT &&
    status.fill_empty |=> state == sbrf_pkg::ST_DONE)
    else $error("empty rectangle entered fill");

endmodule

`default_nettype wire

// ----- rtl/core/sbrf_datapath.sv -----
`default_nettype none

module sbrf_datapath #(
  parameter int SCREEN_WIDTH  = sbrf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sbrf_pkg::SCREEN_HEIGHT_DEF,
  parameter int STRIP_ROWS    = sbrf_pkg::STRIP_ROWS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire sbrf_pkg::cmd_t                       cmd,
  output sbrf_pkg::status_t                         status,
  input  wire logic [1:0]                           opcode,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_x,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_y,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_w,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_h,
  input  wire logic [sbrf_pkg::COLOR_W-1:0]         pixel_color,
  input  wire logic [sbrf_pkg::INDEX_W-1:0]         pixel_index,
  output logic [sbrf_pkg::COLOR_W-1:0]              read_data,
  output logic [sbrf_pkg::TOP_OUT_W-1:0]            strip_top,
  output logic [sbrf_pkg::ROWS_OUT_W-1:0]           strip_rows_used,
  output logic                                      more_strips
);

  localparam int DEPTH  = SCREEN_WIDTH * STRIP_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_W  = $clog2(DEPTH + 1);
  localparam int COL_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int TOP_W  = $clog2(SCREEN_HEIGHT + 1);
  localparam int CNT_W  = $clog2(STRIP_ROWS + 1);
  localparam int SUM_W  = $clog2(SCREEN_HEIGHT + STRIP_ROWS + 1);
  localparam int CW     = sbrf_pkg::CLIP_W;
  localparam int IDX_W  = (LIM_W > sbrf_pkg::INDEX_W) ? LIM_W : sbrf_pkg::INDEX_W;

  localparam logic signed [CW-1:0] ZERO_S  = '0;
  localparam logic signed [CW-1:0] WIDTH_S = CW'(SCREEN_WIDTH);
  localparam logic [SUM_W-1:0]     H_SUM   = SUM_W'(SCREEN_HEIGHT);
  localparam logic [SUM_W-1:0]     R_SUM   = SUM_W'(STRIP_ROWS);
  localparam logic [TOP_W-1:0]     H_TOP   = TOP_W'(SCREEN_HEIGHT);
  localparam logic [CNT_W-1:0]     R_CNT   = CNT_W'(STRIP_ROWS);
  localparam logic [LIM_W-1:0]     W_LIM   = LIM_W'(SCREEN_WIDTH);

  // Latched request
  sbrf_pkg::opcode_t                 op;
  logic signed [sbrf_pkg::COORD_W-1:0] x_q, y_q, w_q, h_q;
  logic [sbrf_pkg::COLOR_W-1:0]      color_q;
  logic [sbrf_pkg::INDEX_W-1:0]      index_q;

  // Strip state
  logic [TOP_W-1:0]             top_row;
  logic [CNT_W-1:0]             line_count;
  logic [sbrf_pkg::COLOR_W-1:0] bg_color;
  logic                         more;

  // Clip results
  logic [COL_W-1:0] left_r, right_r;
  logic [CNT_W-1:0] row_off_r, rows_r;
  logic             empty_r;

  // Walk counters
  logic [LIM_W-1:0] lim, base, clr_addr;
  logic [COL_W-1:0] col;
  logic [CNT_W-1:0] rows_left;
  logic             hit;

  logic [sbrf_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [sbrf_pkg::COLOR_W-1:0] mem_q;

  // Clip arithmetic
  logic signed [CW-1:0] x_e, y_e, w_e, h_e, st_e, sb_e, xr, yb;
  logic signed [CW-1:0] left_c, right_c, top_c, bot_c, row_off_c, rows_c;
  logic                 empty_c;

  assign x_e  = CW'(x_q);
  assign y_e  = CW'(y_q);
  assign w_e  = CW'(w_q);
  assign h_e  = CW'(h_q);
  assign st_e = signed'(CW'(top_row));
  assign sb_e = st_e + signed'(CW'(line_count));
  assign xr   = x_e + w_e;
  assign yb   = y_e + h_e;

  assign left_c    = (x_e > ZERO_S) ? x_e : ZERO_S;
  assign right_c   = (xr < WIDTH_S) ? xr : WIDTH_S;
  assign top_c     = (y_e > st_e) ? y_e : st_e;
  assign bot_c     = (yb < sb_e) ? yb : sb_e;
  assign row_off_c = top_c - st_e;
  assign rows_c    = bot_c - top_c;
  assign empty_c   = (w_e <= ZERO_S) || (h_e <= ZERO_S) ||
                     (left_c >= right_c) || (top_c >= bot_c);

  // Strip advance
  logic [SUM_W-1:0] nt, rem;
  logic             frame_done;
  logic [CNT_W-1:0] count_new;

  assign nt         = SUM_W'(top_row) + SUM_W'(line_count);
  assign frame_done = nt >= H_SUM;
  assign rem        = H_SUM - nt;
  assign count_new  = (rem < R_SUM) ? rem[CNT_W-1:0] : R_CNT;

  // Setup products
  logic [LIM_W-1:0] lim_c, base_c;
  logic [IDX_W-1:0] idx_ext, lim_ext;

  assign lim_c   = LIM_W'(line_count) * W_LIM;
  assign base_c  = LIM_W'(row_off_r) * W_LIM;
  assign idx_ext = IDX_W'(index_q);
  assign lim_ext = IDX_W'(lim_c);

  // Write port
  logic [LIM_W-1:0]             fill_addr;
  logic [ADDR_W-1:0]            wr_addr, rd_addr;
  logic [sbrf_pkg::COLOR_W-1:0] wr_data;
  logic                         wr_en;
  logic [COL_W-1:0]             col_end;

  assign fill_addr = base + LIM_W'(col);
  assign wr_en     = cmd.fill_step || cmd.clear_step;
  assign wr_addr   = cmd.fill_step ? fill_addr[ADDR_W-1:0] : clr_addr[ADDR_W-1:0];
  assign wr_data   = cmd.fill_step ? color_q : bg_color;
  assign rd_addr   = idx_ext[ADDR_W-1:0];
  assign col_end   = right_r - COL_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op      <= sbrf_pkg::opcode_t'(opcode);
      x_q     <= rect_x;
      y_q     <= rect_y;
      w_q     <= rect_w;
      h_q     <= rect_h;
      color_q <= pixel_color;
      index_q <= pixel_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_row    <= '0;
      line_count <= R_CNT;
      bg_color   <= '0;
      more       <= 1'b0;
    end else if (cmd.exec) begin
      case (op)
        sbrf_pkg::OP_BEGIN_FRAME: begin
          bg_color   <= color_q;
          top_row    <= '0;
          line_count <= R_CNT;
          more       <= 1'b0;
        end
        sbrf_pkg::OP_NEXT_STRIP: begin
          if (frame_done) begin
            top_row <= H_TOP;
            more    <= 1'b0;
          end else begin
            top_row    <= nt[TOP_W-1:0];
            line_count <= count_new;
            more       <= 1'b1;
          end
        end
        default: begin
          more <= 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      left_r    <= left_c[COL_W-1:0];
      right_r   <= right_c[COL_W-1:0];
      row_off_r <= row_off_c[CNT_W-1:0];
      rows_r    <= rows_c[CNT_W-1:0];
      empty_r   <= empty_c;
    end
    if (cmd.prep) begin
      lim       <= lim_c;
      base      <= base_c;
      col       <= left_r;
      rows_left <= rows_r;
      clr_addr  <= '0;
      hit       <= idx_ext < lim_ext;
    end
    if (cmd.fill_step) begin
      if (col == col_end) begin
        col       <= left_r;
        base      <= base + W_LIM;
        rows_left <= rows_left - CNT_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
    if (cmd.clear_step) begin
      clr_addr <= clr_addr + LIM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (cmd.read_en && hit) mem_q <= mem[rd_addr];
  end

  logic [TOP_W+sbrf_pkg::TOP_OUT_W-1:0]  top_ext;
  logic [CNT_W+sbrf_pkg::ROWS_OUT_W-1:0] cnt_ext;

  assign top_ext = {{sbrf_pkg::TOP_OUT_W{1'b0}}, top_row};
  assign cnt_ext = {{sbrf_pkg::ROWS_OUT_W{1'b0}}, line_count};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data       <= (op == sbrf_pkg::OP_READ_PIXEL && hit) ? mem_q : '0;
      strip_top       <= top_ext[sbrf_pkg::TOP_OUT_W-1:0];
      strip_rows_used <= cnt_ext[sbrf_pkg::ROWS_OUT_W-1:0];
      more_strips     <= more;
    end
  end

  assign status.op         = op;
  assign status.fill_empty = empty_r;
  assign status.more       = more;
  assign status.fill_last  = (rows_left == CNT_W'(1)) && (col == col_end);
  assign status.clear_last = clr_addr == (lim - LIM_W'(1));

endmodule

`default_nettype wire

// ----- rtl/core/strip_buffer_rect_fill_top.sv -----
// Banded frame renderer: strip buffer with clipped rectangle fill.
// Requests arrive on in_valid/in_ready with opcode and operand ports;
// every request yields exactly one result on out_valid/out_ready
// (read_data, strip_top, strip_rows_used, more_strips).
// Operations: fill_rect clips the signed rectangle to the screen columns
// and the current strip rows, then writes one pixel per cycle; begin_frame
// latches the background, returns to strip 0 and clears the buffer;
// next_strip advances and clears when another strip remains; read_pixel
// returns one buffered pixel, 0 past the rows in use.
// Each request steps through execute and setup, then reads one pixel,
// fills the clipped pixels or clears rows*width entries, and loads the
// result; an empty fill or a finished frame goes straight to the load.
// The single buffer write port writes one pixel per cycle.
// One request is processed at a time; the next is taken the cycle after the
// previous result is loaded, even if not yet taken. If the receiver stalls,
// a finished request waits before its result load until the output
// register frees up.
// Reset (rst, synchronous): strip top 0, full strip height, background 0;
// in_ready stays low while rst is high. The buffer is not cleared by reset;
// begin_frame must precede reads.

`default_nettype none

module strip_buffer_rect_fill_top #(
  parameter int SCREEN_WIDTH  = sbrf_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = sbrf_pkg::SCREEN_HEIGHT_DEF,
  parameter int STRIP_ROWS    = sbrf_pkg::STRIP_ROWS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [1:0]                           opcode,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_x,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_y,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_w,
  input  wire logic signed [sbrf_pkg::COORD_W-1:0]  rect_h,
  input  wire logic [sbrf_pkg::COLOR_W-1:0]         pixel_color,
  input  wire logic [sbrf_pkg::INDEX_W-1:0]         pixel_index,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [sbrf_pkg::COLOR_W-1:0]              read_data,
  output logic [sbrf_pkg::TOP_OUT_W-1:0]            strip_top,
  output logic [sbrf_pkg::ROWS_OUT_W-1:0]           strip_rows_used,
  output logic                                      more_strips
);

  // Command and status between sequencer and datapath
  sbrf_pkg::cmd_t    cmd;
  sbrf_pkg::status_t status;

  // Sequencer: accept, execute, set up, then fill / clear / read when the
  // operation needs it, then load the result register.
  sbrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath: clip math, strip state, buffer memory, result register
  sbrf_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .STRIP_ROWS    (STRIP_ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .opcode          (opcode),
    .rect_x          (rect_x),
    .rect_y          (rect_y),
    .rect_w          (rect_w),
    .rect_h          (rect_h),
    .pixel_color     (pixel_color),
    .pixel_index     (pixel_index),
    .read_data       (read_data),
    .strip_top       (strip_top),
    .strip_rows_used (strip_rows_used),
    .more_strips     (more_strips)
  );

endmodule

`default_nettype wire
